>>> src/ule_pkg.sv
// Shared types, constants and microcode table for the USB line state encoder.
package ule_pkg;

    localparam int STEP_W = 4;
    localparam int BIT_W  = 3;

    localparam logic [STEP_W-1:0] STEP_SYNC = 4'd0;
    localparam logic [STEP_W-1:0] STEP_DATA = 4'd8;
    localparam logic [STEP_W-1:0] STEP_LAST = 4'd13;
    localparam logic [BIT_W-1:0]  BIT_LAST  = 3'd7;

    typedef enum logic [1:0] {
        LS_SE0 = 2'd0,
        LS_SE1 = 2'd1,
        LS_K   = 2'd2,
        LS_J   = 2'd3
    } line_t;

    typedef enum logic {
        KIND_CONST = 1'b0,
        KIND_DATA  = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        BR_NEXT = 2'd0,
        BR_BYTE = 2'd1,
        BR_DONE = 2'd2
    } br_t;

    typedef struct packed {
        kind_t kind;
        line_t ls;
        br_t   br;
    } cw_t;

    // sequencer -> datapath
    typedef struct packed {
        logic  emit;
        logic  load;
        kind_t kind;
        line_t ls;
        logic  eor;
    } ctrl_t;

    // datapath -> sequencer
    typedef struct packed {
        logic out_free;
        logic bit_done;
        logic last;
    } stat_t;

    function automatic cw_t ule_rom(input logic [STEP_W-1:0] pc);
        cw_t cw;
        cw = '{kind: KIND_CONST, ls: LS_J, br: BR_DONE};
        unique case (pc)
            4'd0:    cw = '{kind: KIND_CONST, ls: LS_K,   br: BR_NEXT};
            4'd1:    cw = '{kind: KIND_CONST, ls: LS_J,   br: BR_NEXT};
            4'd2:    cw = '{kind: KIND_CONST, ls: LS_K,   br: BR_NEXT};
            4'd3:    cw = '{kind: KIND_CONST, ls: LS_J,   br: BR_NEXT};
            4'd4:    cw = '{kind: KIND_CONST, ls: LS_K,   br: BR_NEXT};
            4'd5:    cw = '{kind: KIND_CONST, ls: LS_J,   br: BR_NEXT};
            4'd6:    cw = '{kind: KIND_CONST, ls: LS_K,   br: BR_NEXT};
            4'd7:    cw = '{kind: KIND_CONST, ls: LS_K,   br: BR_NEXT};
            4'd8:    cw = '{kind: KIND_DATA,  ls: LS_J,   br: BR_BYTE};
            4'd9:    cw = '{kind: KIND_CONST, ls: LS_SE0, br: BR_NEXT};
            4'd10:   cw = '{kind: KIND_CONST, ls: LS_SE0, br: BR_NEXT};
            4'd11:   cw = '{kind: KIND_CONST, ls: LS_J,   br: BR_NEXT};
            4'd12:   cw = '{kind: KIND_CONST, ls: LS_J,   br: BR_NEXT};
            4'd13:   cw = '{kind: KIND_CONST, ls: LS_J,   br: BR_DONE};
            default: cw = '{kind: KIND_CONST, ls: LS_J,   br: BR_DONE};
        endcase
        return cw;
    endfunction

endpackage

>>> src/ule_ifs.sv
// Handshake channel interfaces for the USB line state encoder.
interface ule_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_first;
    logic       is_last;

    modport source (output valid, data_byte, is_first, is_last, input ready);
    modport sink   (input valid, data_byte, is_first, is_last, output ready);
endinterface

interface ule_out_if;
    logic valid;
    logic ready;
    logic dplus;
    logic dminus;
    logic end_of_run;

    modport source (output valid, dplus, dminus, end_of_run, input ready);
    modport sink   (input valid, dplus, dminus, end_of_run, output ready);
endinterface

interface ule_cfg_if;
    logic valid;
    logic ready;
    logic low_speed;

    modport source (output valid, low_speed, input ready);
    modport sink   (input valid, low_speed, output ready);
endinterface

>>> src/usb_line_state_encoder.sv
// USB line state encoder: sync, NRZI-coded byte LSB first, end of packet.
// Each accepted byte produces one line state per clock while the output is taken:
// 8 states for a plain byte, 16 with sync, 13 with end of packet, 21 with both.
// The microcode emits one state per step, and one per bit at the data step; the
// next item can be accepted once the last state of the previous one has entered
// the output register. No bit stuffing is applied. low_speed swaps the D+/D- levels
// of J and K; the user must write it only while idle, as the block does not enforce it.
module usb_line_state_encoder (
    input  logic      clk,
    input  logic      rst_n,
    ule_in_if.sink    din,
    ule_out_if.source dout,
    ule_cfg_if.sink   cfg
);
    import ule_pkg::*;

    ctrl_t ctrl;
    stat_t stat;
    logic  busy;
    logic  accept;

    assign din.ready = !busy;
    assign accept    = din.valid && !busy;

    ule_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .is_first (din.is_first),
        .stat     (stat),
        .ctrl     (ctrl),
        .busy     (busy)
    );

    ule_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .stat  (stat),
        .din   (din),
        .dout  (dout),
        .cfg   (cfg)
    );

endmodule

>>> src/ule_seq.sv
// Microcode sequencer: step counter, control table lookup and branch logic.
module ule_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic             is_first,
    input  ule_pkg::stat_t   stat,
    output ule_pkg::ctrl_t   ctrl,
    output logic             busy
);
    import ule_pkg::*;

    logic [STEP_W-1:0] pc_reg;
    logic [STEP_W-1:0] pc_next;
    logic              busy_reg;
    logic              busy_next;
    cw_t               cw;
    logic              advance;
    logic              done;

    assign cw      = ule_rom(pc_reg);
    assign advance = busy_reg && stat.out_free;

    always_comb
    begin
        done    = 1'b0;
        pc_next = pc_reg;
        unique case (cw.br)
            BR_NEXT:
            begin
                pc_next = pc_reg + 1'b1;
            end
            BR_BYTE:
            begin
                // stay on the data step until all eight bits are out
                if (stat.bit_done)
                begin
                    if (stat.last)
                        pc_next = pc_reg + 1'b1;
                    else
                        done = 1'b1;
                end
            end
            default:
            begin
                done = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
            busy_next = 1'b1;
        else if (advance && done)
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= STEP_SYNC;
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (accept)
                pc_reg <= is_first ? STEP_SYNC : STEP_DATA;
            else if (advance)
                pc_reg <= pc_next;
        end
    end

    assign ctrl.emit = advance;
    assign ctrl.load = accept;
    assign ctrl.kind = cw.kind;
    assign ctrl.ls   = cw.ls;
    assign ctrl.eor  = done;
    assign busy      = busy_reg;

    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> pc_reg <= STEP_LAST)
        else $error("step counter ran past the end of the program");

    a_end_marks_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> $past(ctrl.emit && ctrl.eor))
        else $error("sequencer went idle without emitting the final line state");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !busy_reg)
        else $error("item accepted while the program was running");

endmodule

>>> src/ule_dp.sv
// Datapath: byte shifter, bit counter, NRZI line state and output register.
module ule_dp (
    input  logic           clk,
    input  logic           rst_n,
    input  ule_pkg::ctrl_t ctrl,
    output ule_pkg::stat_t stat,
    ule_in_if.sink         din,
    ule_out_if.source      dout,
    ule_cfg_if.sink        cfg
);
    import ule_pkg::*;

    logic [7:0]       byte_reg;
    logic [BIT_W-1:0] cnt_reg;
    logic             last_reg;
    logic             low_speed_reg;
    line_t            line_reg;
    line_t            line_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             dp_reg;
    logic             dm_reg;
    logic             eor_reg;
    logic             dp_next;
    logic             dm_next;

    always_comb
    begin
        line_next = line_reg;
        if (ctrl.kind == KIND_DATA)
        begin
            // zero toggles, one holds
            if (byte_reg[0])
                line_next = (line_reg == LS_J) ? LS_J : LS_K;
            else
                line_next = (line_reg == LS_K) ? LS_J : LS_K;
        end
        else
        begin
            line_next = ctrl.ls;
        end
    end

    always_comb
    begin
        unique case (line_next)
            LS_SE0:
            begin
                dp_next = 1'b0;
                dm_next = 1'b0;
            end
            LS_SE1:
            begin
                dp_next = 1'b1;
                dm_next = 1'b1;
            end
            LS_J:
            begin
                dp_next = !low_speed_reg;
                dm_next = low_speed_reg;
            end
            default:
            begin
                dp_next = low_speed_reg;
                dm_next = !low_speed_reg;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.emit)
            out_valid_next = 1'b1;
        else if (dout.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg      <= LS_J;
            low_speed_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
                low_speed_reg <= cfg.low_speed;
            if (ctrl.load)
                cnt_reg <= '0;
            else if (ctrl.emit && ctrl.kind == KIND_DATA)
                cnt_reg <= cnt_reg + 1'b1;
            if (ctrl.emit)
                line_reg <= line_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            byte_reg <= din.data_byte;
            last_reg <= din.is_last;
        end
        else if (ctrl.emit && ctrl.kind == KIND_DATA)
        begin
            byte_reg <= {1'b0, byte_reg[7:1]};
        end
        if (ctrl.emit)
        begin
            dp_reg  <= dp_next;
            dm_reg  <= dm_next;
            eor_reg <= ctrl.eor;
        end
    end

    assign stat.out_free = !out_valid_reg || dout.ready;
    assign stat.bit_done = (cnt_reg == BIT_LAST);
    assign stat.last     = last_reg;

    assign dout.valid      = out_valid_reg;
    assign dout.dplus      = dp_reg;
    assign dout.dminus     = dm_reg;
    assign dout.end_of_run = eor_reg;
    assign cfg.ready       = 1'b1;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.emit |-> (!out_valid_reg || dout.ready))
        else $error("output register overwritten while its item was waiting");

    a_end_on_idle_level: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && eor_reg) |-> (line_reg == LS_J || line_reg == LS_K))
        else $error("run ended with the line outside J or K");

endmodule

>>> verif/tb_usb_line_state_encoder.sv
`timescale 1ns / 1ps
// Self-checking testbench for the USB line state encoder: sync, NRZI byte, end of packet.
module tb_usb_line_state_encoder;
    import ule_pkg::*;

    typedef struct packed {
        logic dplus;
        logic dminus;
        logic end_of_run;
    } pins_t;

    typedef enum logic [1:0] {
        RX_ALWAYS   = 2'd0,
        RX_RANDOM   = 2'd1,
        RX_PERIODIC = 2'd2
    } rx_mode_t;

    logic clk;
    logic rst_n;

    ule_in_if  din_ch ();
    ule_out_if dout_ch ();
    ule_cfg_if cfg_ch ();

    usb_line_state_encoder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_ch),
        .dout  (dout_ch),
        .cfg   (cfg_ch)
    );

    // predicted bus activity, oldest first
    pins_t    pending_states[$];
    line_t    bus_state  = LS_J;
    logic     speed_low  = 1'b0;
    int       mismatches = 0;
    rx_mode_t rx_mode    = RX_ALWAYS;
    int       rx_tick    = 0;
    int       burst_left = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL usb_line_state_encoder");
        $finish;
    end

    function automatic pins_t drive_levels(input line_t s, input logic eor);
        pins_t p;
        case (s)
            LS_SE0:
            begin
                p.dplus  = 1'b0;
                p.dminus = 1'b0;
            end
            LS_SE1:
            begin
                p.dplus  = 1'b1;
                p.dminus = 1'b1;
            end
            LS_J:
            begin
                p.dplus  = ~speed_low;
                p.dminus = speed_low;
            end
            default:
            begin
                p.dplus  = speed_low;
                p.dminus = ~speed_low;
            end
        endcase
        p.end_of_run = eor;
        return p;
    endfunction

    function automatic void encode_byte(input logic [7:0] b, input logic first,
                                        input logic last);
        line_t seq[$];
        line_t nxt;
        if (first)
        begin
            seq = '{LS_K, LS_J, LS_K, LS_J, LS_K, LS_J, LS_K, LS_K};
            bus_state = LS_K;
        end
        // NRZI: zero toggles, one holds
        for (int i = 0; i < 8; i++)
        begin
            if (!b[i])
                nxt = (bus_state == LS_K) ? LS_J : LS_K;
            else
                nxt = (bus_state == LS_J) ? LS_J : LS_K;
            bus_state = nxt;
            seq.push_back(nxt);
        end
        if (last)
        begin
            seq.push_back(LS_SE0);
            seq.push_back(LS_SE0);
            seq.push_back(LS_J);
            seq.push_back(LS_J);
            seq.push_back(LS_J);
            bus_state = LS_J;
        end
        for (int k = 0; k < seq.size(); k++)
            pending_states.push_back(drive_levels(seq[k], k == seq.size() - 1));
    endfunction

    // predict on accepted items, check every accepted line state
    always @(posedge clk)
    begin
        pins_t want;
        pins_t got;
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                speed_low = cfg_ch.low_speed;
            if (din_ch.valid && din_ch.ready)
                encode_byte(din_ch.data_byte, din_ch.is_first, din_ch.is_last);
            if (dout_ch.valid && dout_ch.ready)
            begin
                got = '{dout_ch.dplus, dout_ch.dminus, dout_ch.end_of_run};
                if (pending_states.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected line state dp=%b dm=%b eor=%b", $realtime,
                                 got.dplus, got.dminus, got.end_of_run);
                end
                else
                begin
                    want = pending_states.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: expected dp=%b dm=%b eor=%b, got dp=%b dm=%b eor=%b",
                                     $realtime, want.dplus, want.dminus, want.end_of_run,
                                     got.dplus, got.dminus, got.end_of_run);
                    end
                end
            end
        end
    end

    // output back-pressure
    initial
    begin
        dout_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rx_tick++;
            case (rx_mode)
                RX_ALWAYS:   dout_ch.ready <= 1'b1;
                RX_RANDOM:   dout_ch.ready <= ($urandom_range(0, 9) > 3);
                default:     dout_ch.ready <= ((rx_tick % 11) < 6);
            endcase
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
        if (burst_left == 0)
        begin
            din_ch.valid <= 1'b0;
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(10, 30)) @(posedge clk);
            else
                repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        din_ch.valid     <= 1'b1;
        din_ch.data_byte <= b;
        din_ch.is_first  <= first;
        din_ch.is_last   <= last;
        @(posedge clk);
        while (!din_ch.ready)
            @(posedge clk);
    endtask

    // drop valid and wait until every predicted line state has come out
    task automatic wait_idle();
        din_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_states.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_speed(input logic v);
        wait_idle();
        cfg_ch.valid     <= 1'b1;
        cfg_ch.low_speed <= v;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic test_plain_bytes();
        rx_mode = RX_ALWAYS;
        write_speed(1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h01, 1'b0, 1'b0);
        send_byte(8'h80, 1'b0, 1'b0);
        send_byte(8'hAA, 1'b0, 1'b0);
        send_byte(8'h55, 1'b0, 1'b0);
    endtask

    task automatic test_sync_and_eop();
        rx_mode = RX_PERIODIC;
        send_byte(8'h3C, 1'b1, 1'b0);
        send_byte(8'hC3, 1'b0, 1'b1);
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(8'hFF, 1'b1, 1'b1);
        send_byte(8'h5A, 1'b1, 1'b1);
    endtask

    // J and K swap pins; SE0 stays low on both
    task automatic test_low_speed();
        rx_mode = RX_RANDOM;
        write_speed(1'b1);
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h96, 1'b1, 1'b0);
        send_byte(8'h69, 1'b0, 1'b1);
        send_byte(8'h00, 1'b0, 1'b0);
        write_speed(1'b0);
    endtask

    // mostly framed packets with random content, some loose bytes with random flags
    task automatic test_random_packets();
        int sent;
        int len;
        for (int phase = 0; phase < 5; phase++)
        begin
            if (phase < 2)
                write_speed(phase[0] ? 1'b0 : 1'b1);
            else
                write_speed(1'($urandom_range(0, 1)));
            rx_mode = rx_mode_t'(phase % 3);
            sent = 0;
            while (sent < 30)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
                    sent++;
                end
                else
                begin
                    len = $urandom_range(1, 6);
                    for (int i = 0; i < len; i++)
                        send_byte(8'($urandom_range(0, 255)), i == 0, i == len - 1);
                    sent += len;
                end
            end
        end
    endtask

    initial
    begin
        rst_n            <= 1'b0;
        din_ch.valid     <= 1'b0;
        din_ch.data_byte <= 8'h00;
        din_ch.is_first  <= 1'b0;
        din_ch.is_last   <= 1'b0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.low_speed <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_plain_bytes();
        test_sync_and_eop();
        test_low_speed();
        test_random_packets();
        wait_idle();
        repeat (30) @(posedge clk);
        if (mismatches == 0 && pending_states.size() == 0)
            $display("PASS usb_line_state_encoder");
        else
            $display("FAIL usb_line_state_encoder");
        $finish;
    end

endmodule

>>> filelist.f
src/ule_pkg.sv
src/ule_ifs.sv
src/ule_seq.sv
src/ule_dp.sv
src/usb_line_state_encoder.sv
verif/tb_usb_line_state_encoder.sv
